// ===== rtl/core/bilinear_height_sampler_unit_defines.svh =====
// ----------------------------------------------------------------------------
// bilinear height sampler assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef BILINEAR_HEIGHT_SAMPLER_UNIT_DEFINES_SVH
`define BILINEAR_HEIGHT_SAMPLER_UNIT_DEFINES_SVH

// checked outside reset
`define BHS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("bhs assertion failed");

// checked at every edge, reset included
`define BHS_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("bhs assertion failed");

`endif

// ===== rtl/core/bhs_pkg.sv =====
// ----------------------------------------------------------------------------
// bhs_pkg
// widths and constants of the bilinear height sampler
// ----------------------------------------------------------------------------
package bhs_pkg;

	localparam int GRID_SIZE  = 32;
	localparam int FRAC_BITS  = 8;
	localparam int HEIGHT_W   = 16;
	localparam int CELL_W     = 5;
	localparam int COORD_W    = 14;

	localparam int BANK_AW    = 2 * (CELL_W - 1);
	localparam int BANK_DEPTH = 1 << BANK_AW;
	localparam int WEIGHT_W   = FRAC_BITS + 1;
	localparam int ONE        = 1 << FRAC_BITS;
	localparam int ROW_W      = HEIGHT_W + FRAC_BITS;
	localparam int ROW_PW     = HEIGHT_W + WEIGHT_W;
	localparam int SUM_W      = ROW_W + WEIGHT_W;

endpackage

// ===== rtl/core/bilinear_height_sampler_unit.sv =====
// a query result is registered in stage s1, stage s2 and the output register in turn
// throughput: one item per cycle while the result side keeps taking results
// a stalled result holds the whole pipeline and the input side
// reset: asynchronous active low, clears the valid flags only
// height store is four parity banks of sram, not cleared by reset
// ----------------------------------------------------------------------------
// bilinear_height_sampler_unit
// height grid store with bilinear query, the four banks read in the same cycle
// ----------------------------------------------------------------------------
module bilinear_height_sampler_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                operation,
	input  logic [bhs_pkg::CELL_W-1:0]          cell_x,
	input  logic [bhs_pkg::CELL_W-1:0]          cell_z,
	input  logic [bhs_pkg::HEIGHT_W-1:0]        height_value,
	input  logic signed [bhs_pkg::COORD_W-1:0]  coord_x,
	input  logic signed [bhs_pkg::COORD_W-1:0]  coord_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [bhs_pkg::HEIGHT_W-1:0]        height_out,
	output logic                                in_range
);
	import bhs_pkg::*;

	localparam logic signed [COORD_W-1:0] LIMIT = COORD_W'((GRID_SIZE - 1) << FRAC_BITS);
	localparam logic [WEIGHT_W-1:0] ONE_W = WEIGHT_W'(ONE);

	logic                advance;
	logic                query_xfer;
	logic                wr_en;
	logic [1:0]          wr_bank;
	logic [BANK_AW-1:0]  wr_addr;
	logic [CELL_W-1:0]   xi, zi, xi1, zi1;
	logic [WEIGHT_W-1:0] dx, dz, one_m_dx, one_m_dz;
	logic                q_in_range;

	logic [HEIGHT_W-1:0] rd_s1 [4];
	logic [WEIGHT_W-1:0] wx_even_s1, wx_odd_s1, wz_even_s1, wz_odd_s1;
	logic                valid_s1, inr_s1;

	logic [ROW_W-1:0]    row_s2 [2];
	logic [WEIGHT_W-1:0] wz_even_s2, wz_odd_s2;
	logic                valid_s2, inr_s2;

	logic [SUM_W-1:0]    blend;

	logic                out_valid_q, in_range_q;
	logic [HEIGHT_W-1:0] height_out_q;

	assign advance    = !(out_valid_q && !out_ready);
	assign in_ready   = advance;
	assign query_xfer = in_valid && advance && operation;

	assign wr_en   = in_valid && advance && !operation
		&& (int'(cell_x) < GRID_SIZE) && (int'(cell_z) < GRID_SIZE);
	assign wr_bank = {cell_x[0], cell_z[0]};
	assign wr_addr = {cell_x[CELL_W-1:1], cell_z[CELL_W-1:1]};

	assign xi  = coord_x[FRAC_BITS +: CELL_W];
	assign zi  = coord_z[FRAC_BITS +: CELL_W];
	assign xi1 = xi + CELL_W'(1);
	assign zi1 = zi + CELL_W'(1);
	assign dx  = {1'b0, coord_x[FRAC_BITS-1:0]};
	assign dz  = {1'b0, coord_z[FRAC_BITS-1:0]};
	assign one_m_dx = ONE_W - dx;
	assign one_m_dz = ONE_W - dz;

	assign q_in_range = !coord_x[COORD_W-1] && !coord_z[COORD_W-1]
		&& (coord_x < LIMIT) && (coord_z < LIMIT);

	// bank index is {x parity, z parity}, each bank holds one corner
	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic PX = 1'(b >> 1);
		localparam logic PZ = 1'(b & 1);

		logic [HEIGHT_W-1:0] mem [BANK_DEPTH];
		logic [CELL_W-1:0]   xa, za;
		logic [BANK_AW-1:0]  rd_addr;

		assign xa      = (xi[0] == PX) ? xi : xi1;
		assign za      = (zi[0] == PZ) ? zi : zi1;
		assign rd_addr = {xa[CELL_W-1:1], za[CELL_W-1:1]};

		always_ff @(posedge clk) begin
			if (wr_en && (wr_bank == 2'(b))) begin
				mem[wr_addr] <= height_value;
			end
			if (query_xfer) begin
				rd_s1[b] <= mem[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (query_xfer) begin
			inr_s1     <= q_in_range;
			wx_even_s1 <= xi[0] ? dx : one_m_dx;
			wx_odd_s1  <= xi[0] ? one_m_dx : dx;
			wz_even_s1 <= zi[0] ? dz : one_m_dz;
			wz_odd_s1  <= zi[0] ? one_m_dz : dz;
		end
	end

	// blend along x, one row per z parity
	for (genvar pz = 0; pz < 2; pz++) begin : g_row
		logic [ROW_PW-1:0] prod_even, prod_odd, row_sum;

		assign prod_even = ROW_PW'(rd_s1[pz]) * ROW_PW'(wx_even_s1);
		assign prod_odd  = ROW_PW'(rd_s1[2 + pz]) * ROW_PW'(wx_odd_s1);
		assign row_sum   = prod_even + prod_odd;

		always_ff @(posedge clk) begin
			if (advance && valid_s1) begin
				row_s2[pz] <= row_sum[ROW_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			inr_s2     <= inr_s1;
			wz_even_s2 <= wz_even_s1;
			wz_odd_s2  <= wz_odd_s1;
		end
	end

	// blend along z
	assign blend = SUM_W'(row_s2[0]) * SUM_W'(wz_even_s2)
		+ SUM_W'(row_s2[1]) * SUM_W'(wz_odd_s2);

	always_ff @(posedge clk) begin
		if (advance && valid_s2) begin
			in_range_q   <= inr_s2;
			height_out_q <= inr_s2 ? blend[2*FRAC_BITS +: HEIGHT_W] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= query_xfer;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	assign out_valid  = out_valid_q;
	assign height_out = height_out_q;
	assign in_range   = in_range_q;

endmodule

// ===== rtl/core/bhs_checker.sv =====
// ----------------------------------------------------------------------------
// bhs_checker
// port level checks of the bilinear height sampler, bound to the sampler unit
// ----------------------------------------------------------------------------
`include "bilinear_height_sampler_unit_defines.svh"

module bhs_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [bhs_pkg::HEIGHT_W-1:0] height_out,
	input logic                         in_range
);
	import bhs_pkg::*;

	// stalled result holds
	`BHS_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable({height_out, in_range}))

	// query outside the grid gives zero
	`BHS_ASSERT(a_zero_outside, clk, arst_n, out_valid && !in_range |-> height_out == '0)

	// input side waits only on a stalled result
	`BHS_ASSERT(a_ready_stall, clk, arst_n, !in_ready |-> out_valid && !out_ready)

	// no result after a reset edge
	`BHS_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |=> !out_valid)

endmodule

bind bilinear_height_sampler_unit bhs_checker u_bhs_checker (.*);
